>>> rtl/uprd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uprd_pkg: shared types and constants of the url percent decoder
// Character codes, escape phase type, the char list passed from the
// decoder to the output sequencer, and the hex helper functions.
// ----------------------------------------------------------------------------
package uprd_pkg;

  // character codes
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // most decoded chars one input byte can produce
  localparam int unsigned MaxChars = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_e;

  // decoded chars of one transaction, before entity and line-break mapping
  typedef struct packed {
    logic [MaxChars-1:0][7:0] ch;
    logic [1:0]               cnt;
    logic                     last;
  } chars_t;

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h41) && (b <= 8'h46)) ||
           ((b >= 8'h61) && (b <= 8'h66));
  endfunction

  // only meaningful for a valid hex digit
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    if (b <= 8'h39) begin
      return b[3:0];
    end
    return b[3:0] + 4'd9;
  endfunction

endpackage
`default_nettype wire

>>> rtl/uprd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uprd_if: stream interfaces of the url percent decoder
// Input byte channel, output byte channel and configuration write channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface uprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface uprd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface uprd_cfg_if;
  logic valid;
  logic ready;
  logic tag_escape;

  modport source (output valid, output tag_escape, input ready);
  modport sink   (input valid, input tag_escape, output ready);
endinterface
`default_nettype wire

>>> rtl/uprd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uprd_decode: percent escape decoder
// Holds the escape phase and the first hex digit, and turns one input byte
// into up to three decoded chars when the byte is handed on.
// ----------------------------------------------------------------------------
module uprd_decode
  import uprd_pkg::*;
(
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic [7:0] byte_i,
  input  var logic       last_i,
  input  var logic       load_i,
  output chars_t         chars_o
);

  phase_e              phase_q, phase_d;
  logic   [7:0]        fd_q, fd_d;
  logic   [MaxChars-1:0][7:0] ch;
  logic   [1:0]        n;
  logic                idle_go;

  // next phase and decoded char list
  always_comb begin
    ch      = '0;
    n       = 2'd0;
    phase_d = phase_q;
    fd_d    = fd_q;
    idle_go = 1'b0;
    unique case (phase_q)
      PH_PCT: begin
        if (is_hex(byte_i)) begin
          fd_d    = byte_i;
          phase_d = PH_DIG;
        end else begin
          phase_d = PH_IDLE;
          ch[n]   = CH_PCT;
          n       = n + 2'd1;
          idle_go = 1'b1;
        end
      end
      PH_DIG: begin
        phase_d = PH_IDLE;
        if (is_hex(byte_i)) begin
          ch[n] = {hex_val(fd_q), hex_val(byte_i)};
          n     = n + 2'd1;
        end else begin
          ch[n]   = CH_PCT;
          n       = n + 2'd1;
          ch[n]   = fd_q;
          n       = n + 2'd1;
          idle_go = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        idle_go = 1'b1;
      end
    endcase

    // byte seen from the idle state
    if (idle_go) begin
      if (byte_i == CH_PCT) begin
        phase_d = PH_PCT;
      end else begin
        ch[n] = (byte_i == CH_PLUS) ? CH_SP : byte_i;
        n     = n + 2'd1;
      end
    end

    // flush a pending escape at the end of a message
    if (last_i) begin
      if (phase_d == PH_PCT) begin
        ch[n] = CH_PCT;
        n     = n + 2'd1;
      end else if (phase_d == PH_DIG) begin
        ch[n] = CH_PCT;
        n     = n + 2'd1;
        ch[n] = fd_d;
        n     = n + 2'd1;
      end
      phase_d = PH_IDLE;
    end
  end

  assign chars_o.ch   = ch;
  assign chars_o.cnt  = n;
  assign chars_o.last = last_i;

  // escape state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fd_q    <= 8'h00;
    end else if (load_i) begin
      phase_q <= phase_d;
      fd_q    <= fd_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/uprd_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uprd_emit: output sequencer
// Holds one transaction's decoded chars and sends one byte per cycle while
// ready; line breaks map to spaces, with tag_escape brackets map to entities.
// ----------------------------------------------------------------------------
module uprd_emit
  import uprd_pkg::*;
(
  input  var logic   clk_i,
  input  var logic   rst_ni,
  input  var logic   tag_escape_i,
  input  var logic   load_i,
  input  var chars_t chars_i,
  output logic       free_o,
  uprd_out_if.source out_o
);

  logic [MaxChars-1:0][7:0] ch_q;
  logic [1:0]               cnt_q;
  logic                     last_q;
  logic [1:0]               ci_q;
  logic [1:0]               sub_q;
  logic [7:0]               cur;
  logic                     entity;
  logic                     elem_final;
  logic                     item_final;
  logic                     fire;
  logic [7:0]               obyte;

  assign cur        = ch_q[ci_q];
  assign entity     = tag_escape_i && ((cur == CH_LT) || (cur == CH_GT));
  assign elem_final = !entity || (sub_q == 2'd3);
  assign item_final = elem_final && (ci_q == (cnt_q - 2'd1));
  assign fire       = out_o.valid && out_o.ready;
  assign free_o     = (cnt_q == 2'd0) || (fire && item_final);

  // output byte mapping
  always_comb begin
    if (entity) begin
      case (sub_q)
        2'd0:    obyte = CH_AMP;
        2'd1:    obyte = (cur == CH_LT) ? CH_L : CH_G;
        2'd2:    obyte = CH_T;
        default: obyte = CH_SEMI;
      endcase
    end else if ((cur == CH_CR) || (cur == CH_LF)) begin
      obyte = CH_SP;
    end else begin
      obyte = cur;
    end
  end

  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = obyte;
  assign out_o.out_last = last_q && item_final;

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      ci_q  <= 2'd0;
      sub_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= chars_i.cnt;
      ci_q  <= 2'd0;
      sub_q <= 2'd0;
    end else if (fire) begin
      if (elem_final) begin
        sub_q <= 2'd0;
        if (item_final) begin
          cnt_q <= 2'd0;
        end else begin
          ci_q <= ci_q + 2'd1;
        end
      end else begin
        sub_q <= sub_q + 2'd1;
      end
    end
  end

  // char payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ch_q   <= chars_i.ch;
      last_q <= chars_i.last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/url_percent_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming form-encoded text decoder
// Input register, escape decoder and byte-wise output sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one raw byte per transaction, in_last marks the final byte of a
//           message and flushes a pending '%' and digit literally.
//   out_o : one decoded byte per transaction, out_last on the final byte
//           that a last-marked input produces.
//   cfg_i : tag_escape write, always ready; write only while the block idles.
//   A byte that produces output passes the input register and is then
//   offered from the output sequencer register.
//   Throughput: one input byte per cycle while each byte gives at most one
//   output byte and the receiver is ready; the output sequencer sends one
//   byte per cycle while the receiver is ready, so a byte that expands (an
//   entity gives four, a broken escape up to six) holds the input until its
//   last byte is sent. A '%' or a first digit gives no output.
//   Reset clears the escape phase, tag_escape and both pipeline stages.
//   When the receiver stalls, the sequencer holds its byte, at most one
//   further input transaction is taken into the input register, then
//   in_i.ready falls until the sequencer frees.
// ----------------------------------------------------------------------------
module url_percent_decoder
  import uprd_pkg::*;
(
  input  var logic    clk_i,
  input  var logic    rst_ni,
  uprd_in_if.sink     in_i,
  uprd_out_if.source  out_o,
  uprd_cfg_if.sink    cfg_i
);

  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_last_q;
  logic       tag_escape_q;
  logic       free;
  logic       load;
  chars_t     chars;

  // input register hands on when the sequencer frees
  assign load       = a_valid_q && free;
  assign in_i.ready = !a_valid_q || load;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      a_valid_q <= 1'b1;
    end else if (load) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      a_byte_q <= in_i.in_byte;
      a_last_q <= in_i.in_last;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_escape_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tag_escape_q <= cfg_i.tag_escape;
    end
  end

  uprd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (a_byte_q),
    .last_i  (a_last_q),
    .load_i  (load),
    .chars_o (chars)
  );

  uprd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_escape_i (tag_escape_q),
    .load_i       (load),
    .chars_i      (chars),
    .free_o       (free),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

>>> dv/url_percent_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_test: self-checking bench for the url percent decoder
// Drives encoded byte streams through the input channel with random gaps.
// The output channel is stalled at random, with one long hold-off.
// A local decoder predicts each decoded byte and its last flag; every output
// transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module url_percent_decoder_test
  import uprd_pkg::*;
();

  localparam logic [7:0] HEX_0  = "0";
  localparam logic [7:0] HEX_9  = "9";
  localparam logic [7:0] HEX_UA = "A";
  localparam logic [7:0] HEX_UF = "F";
  localparam logic [7:0] HEX_LA = "a";
  localparam logic [7:0] HEX_LF = "f";
  localparam int unsigned LongHold = 80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } plain_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  uprd_in_if  in_bus ();
  uprd_out_if out_bus ();
  uprd_cfg_if cfg_bus ();

  url_percent_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // encoded bytes waiting to be sent, decoded bytes waiting to arrive
  raw_byte_t   raw_fifo[$];
  plain_byte_t decoded_fifo[$];

  // decoder copy of the block's state and register
  phase_e      esc_phase  = PH_IDLE;
  logic [7:0]  held_digit = 8'h00;
  logic        tag_mode   = 1'b0;
  logic [7:0]  step_chars[$];

  int unsigned error_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned hold_left      = 0;
  int unsigned long_hold_req  = 0;
  int unsigned long_hold_seen = 0;
  logic        calm_mode      = 1'b0;
  raw_byte_t   send_item;
  plain_byte_t want;
  logic [7:0]  msg_q[$];

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic is_hex_char(input logic [7:0] b);
    return (b >= HEX_0 && b <= HEX_9) || (b >= HEX_UA && b <= HEX_UF) ||
           (b >= HEX_LA && b <= HEX_LF);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] b);
    logic [7:0] v;
    if (b <= HEX_9) begin
      v = b - HEX_0;
    end else if (b <= HEX_UF) begin
      v = b - HEX_UA + 8'd10;
    end else begin
      v = b - HEX_LA + 8'd10;
    end
    return v[3:0];
  endfunction

  // output stage: entities and line-break mapping
  function automatic void map_char(input logic [7:0] ch);
    if (tag_mode && (ch == CH_LT || ch == CH_GT)) begin
      step_chars.push_back(CH_AMP);
      step_chars.push_back(ch == CH_LT ? CH_L : CH_G);
      step_chars.push_back(CH_T);
      step_chars.push_back(CH_SEMI);
    end else if (ch == CH_CR || ch == CH_LF) begin
      step_chars.push_back(CH_SP);
    end else begin
      step_chars.push_back(ch);
    end
  endfunction

  // a byte seen with no escape pending
  function automatic void take_plain(input logic [7:0] b);
    if (b == CH_PCT) begin
      esc_phase = PH_PCT;
    end else if (b == CH_PLUS) begin
      map_char(CH_SP);
    end else begin
      map_char(b);
    end
  endfunction

  // decode one encoded byte and queue the bytes it yields
  function automatic void decode_step(input logic [7:0] b, input logic last);
    step_chars.delete();
    case (esc_phase)
      PH_PCT: begin
        if (is_hex_char(b)) begin
          held_digit = b;
          esc_phase  = PH_DIG;
        end else begin
          esc_phase = PH_IDLE;
          map_char(CH_PCT);
          take_plain(b);
        end
      end
      PH_DIG: begin
        esc_phase = PH_IDLE;
        if (is_hex_char(b)) begin
          map_char({digit_value(held_digit), digit_value(b)});
        end else begin
          map_char(CH_PCT);
          map_char(held_digit);
          take_plain(b);
        end
      end
      default: begin
        esc_phase = PH_IDLE;
        take_plain(b);
      end
    endcase
    // end of message flushes a pending escape literally
    if (last) begin
      if (esc_phase == PH_PCT) begin
        map_char(CH_PCT);
      end else if (esc_phase == PH_DIG) begin
        map_char(CH_PCT);
        map_char(held_digit);
      end
      esc_phase = PH_IDLE;
    end
    foreach (step_chars[i]) begin
      decoded_fifo.push_back('{step_chars[i], last && (i == step_chars.size() - 1)});
    end
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned draw_gap();
    int unsigned r;
    if (calm_mode) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) begin
      return HEX_0 + 8'(r);
    end else if (r < 16) begin
      return HEX_UA + 8'(r - 10);
    end
    return HEX_LA + 8'(r - 16);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_hex_char(b));
    return b;
  endfunction

  // input driver: predicts each accepted transaction, then offers the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        decode_step(in_bus.in_byte, in_bus.in_last);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (raw_fifo.size() > 0) begin
          send_item = raw_fifo.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.in_byte <= send_item.in_byte;
          in_bus.in_last <= send_item.in_last;
          send_gap = draw_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end else begin
      in_bus.valid   <= 1'b0;
      in_bus.in_byte <= 8'h00;
      in_bus.in_last <= 1'b0;
    end
  end

  // output monitor: checks each transaction and paces ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (decoded_fifo.size() == 0) begin
          $display("%0t: unexpected output, expected none, actual byte %h last %b",
                   $time, out_bus.out_byte, out_bus.out_last);
          error_count++;
        end else begin
          want = decoded_fifo.pop_front();
          if (want.out_byte !== out_bus.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, want.out_byte, out_bus.out_byte);
            error_count++;
          end
          if (want.out_last !== out_bus.out_last) begin
            $display("%0t: out_last mismatch, expected %b, actual %b",
                     $time, want.out_last, out_bus.out_last);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (long_hold_req != long_hold_seen) begin
        // long hold-off so the block fills up and stalls its input
        long_hold_seen = long_hold_req;
        hold_left = LongHold - 1;
        out_bus.ready <= 1'b0;
      end else begin
        hold_left = draw_gap();
        if (hold_left == 0) begin
          out_bus.ready <= 1'b1;
        end else begin
          hold_left = hold_left - 1;
          out_bus.ready <= 1'b0;
        end
      end
    end else begin
      out_bus.ready <= 1'b0;
    end
  end

  task automatic queue_raw(input logic [7:0] b, input logic last);
    raw_fifo.push_back('{b, last});
  endtask

  task automatic queue_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      queue_raw(s[i], last && (i == s.len() - 1));
    end
  endtask

  // wait for every byte sent and every decoded byte received
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (raw_fifo.size() != 0 || in_bus.valid || decoded_fifo.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tag(input logic v);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.tag_escape <= v;
    do begin
      @(posedge clk_i);
    end while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    tag_mode = v;
  endtask

  // random messages of escapes, plain bytes and noise
  task automatic fill_random(input int unsigned count);
    int unsigned added;
    int unsigned tokens;
    int unsigned r;
    added = 0;
    while (added < count) begin
      msg_q.delete();
      tokens = $urandom_range(1, 6);
      for (int t = 0; t < tokens; t++) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          msg_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 40) begin
          msg_q.push_back(CH_PLUS);
        end else if (r < 48) begin
          msg_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end else if (r < 58) begin
          msg_q.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
        end else if (r < 78) begin
          msg_q.push_back(CH_PCT);
          msg_q.push_back(rand_hex());
          msg_q.push_back(rand_hex());
        end else if (r < 86) begin
          msg_q.push_back(CH_PCT);
          msg_q.push_back(rand_non_hex());
        end else if (r < 94) begin
          msg_q.push_back(CH_PCT);
          msg_q.push_back(rand_hex());
          msg_q.push_back(rand_non_hex());
        end else begin
          msg_q.push_back(CH_PCT);
          if ($urandom_range(0, 1)) msg_q.push_back(rand_hex());
        end
      end
      // dangling escape at the end of some messages
      if ($urandom_range(0, 4) == 0) begin
        msg_q.push_back(CH_PCT);
        if ($urandom_range(0, 1)) msg_q.push_back(rand_hex());
      end
      foreach (msg_q[i]) begin
        queue_raw(msg_q[i], (i == msg_q.size() - 1) || ($urandom_range(0, 39) == 0));
      end
      added += msg_q.size();
    end
  endtask

  // main sequence
  initial begin
    cfg_bus.valid      = 1'b0;
    cfg_bus.tag_escape = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_tag(1'b0);

    // directed, no tag escaping: byte extremes, plus, line breaks, escapes
    queue_raw(8'h00, 1'b0);
    queue_raw(8'hFF, 1'b0);
    queue_raw(CH_PLUS, 1'b0);
    queue_raw(CH_CR, 1'b0);
    queue_raw(CH_LF, 1'b0);
    queue_text("%2B%00%G%az%7", 1'b1);
    wait_drained();

    // directed, tag escaping on: entities, decoded bracket, lone percent
    write_tag(1'b1);
    queue_raw(CH_LT, 1'b0);
    queue_raw(CH_GT, 1'b0);
    queue_text("%3c%a<", 1'b0);
    queue_raw(CH_PCT, 1'b1);
    wait_drained();

    fill_random(35);
    wait_drained();

    // no idling on either side
    write_tag(1'b0);
    calm_mode = 1'b1;
    fill_random(35);
    wait_drained();
    calm_mode = 1'b0;

    // receiver hold-off while the sender keeps offering
    write_tag(1'b1);
    long_hold_req++;
    fill_random(35);
    wait_drained();

    write_tag(1'b0);
    fill_random(35);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
